/* src/i8080d_pkg.sv */
// ----------------------------------------------------------------------------
// i8080d_pkg
// Shared types, codes and the opcode decode table of the 8080 opcode decoder.
// ----------------------------------------------------------------------------
package i8080d_pkg;

	localparam int OpcodeW = 8;
	localparam int ClassW  = 5;
	localparam int SubW    = 3;
	localparam int RegW    = 3;
	localparam int PairW   = 2;
	localparam int CostW   = 5;
	localparam int FaultW  = 2;
	localparam int InDataW  = 16;
	localparam int OutDataW = 32;

	localparam logic [ClassW-1:0] CLS_NOP     = 5'd0;
	localparam logic [ClassW-1:0] CLS_LXI     = 5'd1;
	localparam logic [ClassW-1:0] CLS_DAD     = 5'd2;
	localparam logic [ClassW-1:0] CLS_LHLD    = 5'd3;
	localparam logic [ClassW-1:0] CLS_LDA     = 5'd4;
	localparam logic [ClassW-1:0] CLS_LDAX    = 5'd5;
	localparam logic [ClassW-1:0] CLS_SHLD    = 5'd6;
	localparam logic [ClassW-1:0] CLS_STA     = 5'd7;
	localparam logic [ClassW-1:0] CLS_STAX    = 5'd8;
	localparam logic [ClassW-1:0] CLS_INX     = 5'd9;
	localparam logic [ClassW-1:0] CLS_DCX     = 5'd10;
	localparam logic [ClassW-1:0] CLS_INR     = 5'd11;
	localparam logic [ClassW-1:0] CLS_DCR     = 5'd12;
	localparam logic [ClassW-1:0] CLS_MVI     = 5'd13;
	localparam logic [ClassW-1:0] CLS_ROTATE  = 5'd14;
	localparam logic [ClassW-1:0] CLS_SPECIAL = 5'd15;
	localparam logic [ClassW-1:0] CLS_MOV     = 5'd16;
	localparam logic [ClassW-1:0] CLS_ALU_REG = 5'd17;
	localparam logic [ClassW-1:0] CLS_ALU_IMM = 5'd18;
	localparam logic [ClassW-1:0] CLS_PUSH    = 5'd19;
	localparam logic [ClassW-1:0] CLS_POP     = 5'd20;
	localparam logic [ClassW-1:0] CLS_JMP     = 5'd21;
	localparam logic [ClassW-1:0] CLS_RET     = 5'd22;
	localparam logic [ClassW-1:0] CLS_CALL    = 5'd23;
	localparam logic [ClassW-1:0] CLS_OUT     = 5'd24;
	localparam logic [ClassW-1:0] CLS_IN      = 5'd25;
	localparam logic [ClassW-1:0] CLS_XTHL    = 5'd26;
	localparam logic [ClassW-1:0] CLS_PCHL    = 5'd27;
	localparam logic [ClassW-1:0] CLS_XCHG    = 5'd28;
	localparam logic [ClassW-1:0] CLS_DI      = 5'd29;
	localparam logic [ClassW-1:0] CLS_EI      = 5'd30;
	localparam logic [ClassW-1:0] CLS_NONE    = 5'd31;

	localparam logic [FaultW-1:0] FAULT_NONE  = 2'd0;
	localparam logic [FaultW-1:0] FAULT_HALT  = 2'd1;
	localparam logic [FaultW-1:0] FAULT_UNIMP = 2'd2;

	localparam logic [RegW-1:0] REG_M = 3'd6;

	localparam logic [1:0] KIND_RET  = 2'd0;
	localparam logic [1:0] KIND_JMP  = 2'd1;
	localparam logic [1:0] KIND_CALL = 2'd2;

	localparam logic [OpcodeW-1:0] OP_HLT = 8'h76;

	typedef struct packed {
		logic [ClassW-1:0] cls;
		logic [SubW-1:0]   sub;
		logic [RegW-1:0]   dst;
		logic [RegW-1:0]   src;
		logic [PairW-1:0]  pair;
		logic [CostW-1:0]  cost_taken;
		logic [CostW-1:0]  cost_untaken;
		logic              is_cond;
		logic              uncond_taken;
		logic              may_skip;
		logic [1:0]        cond_sel;
		logic              cond_val;
		logic [FaultW-1:0] fault;
	} rom_entry_t;

	typedef struct packed {
		logic [ClassW-1:0] cls;
		logic [SubW-1:0]   sub;
		logic [RegW-1:0]   dst;
		logic [RegW-1:0]   src;
		logic [PairW-1:0]  pair;
		logic [CostW-1:0]  cost;
		logic              taken;
		logic              skip;
		logic [FaultW-1:0] fault;
	} result_t;

	typedef struct packed {
		logic sign;
		logic parity;
		logic carry;
		logic zero;
	} flags_t;

	function automatic rom_entry_t rom_data(input logic [OpcodeW-1:0] op);
		rom_entry_t e;
		logic [CostW-1:0] c;
		e = '0;
		c = '0;
		case (op[7:6])
			2'd0: begin
				if (op == 8'h00) begin
					e.cls = CLS_NOP; c = 5'd4;
				end else if (op[3:0] == 4'h1) begin
					e.cls = CLS_LXI; c = 5'd10; e.pair = op[5:4];
				end else if (op[3:0] == 4'h9) begin
					e.cls = CLS_DAD; c = 5'd10; e.pair = op[5:4];
				end else if (op[2:0] == 3'd2) begin
					if (op[5]) begin
						if (op[3]) e.cls = op[4] ? CLS_LDA : CLS_LHLD;
						else       e.cls = op[4] ? CLS_STA : CLS_SHLD;
						c = op[4] ? 5'd13 : 5'd16;
					end else begin
						e.cls  = op[3] ? CLS_LDAX : CLS_STAX;
						c      = 5'd7;
						e.pair = {1'b0, op[4]};
					end
				end else if (op[2:0] == 3'd3) begin
					e.cls = op[3] ? CLS_DCX : CLS_INX; c = 5'd5; e.pair = op[5:4];
				end else if (op[2:1] == 2'd2) begin
					e.cls = op[0] ? CLS_DCR : CLS_INR;
					c     = (op[5:3] == REG_M) ? 5'd10 : 5'd5;
					e.dst = op[5:3];
				end else if (op[2:0] == 3'd6) begin
					e.cls = CLS_MVI;
					c     = (op[5:3] == REG_M) ? 5'd10 : 5'd7;
					e.dst = op[5:3];
				end else if ((op & 8'h27) == 8'h07) begin
					e.cls = CLS_ROTATE; c = 5'd4; e.sub = {1'b0, op[4:3]};
				end else if ((op & 8'h27) == 8'h27) begin
					e.cls = CLS_SPECIAL; c = 5'd4; e.sub = {1'b0, op[4:3]};
				end else begin
					e.fault = FAULT_UNIMP;
				end
			end
			2'd1: begin
				if (op == OP_HLT) begin
					e.fault = FAULT_HALT;
				end else begin
					e.cls = CLS_MOV;
					e.dst = op[5:3];
					e.src = op[2:0];
					c = (op[5:3] == REG_M || op[2:0] == REG_M) ? 5'd7 : 5'd4;
				end
			end
			2'd2: begin
				e.cls = CLS_ALU_REG;
				e.sub = op[5:3];
				e.src = op[2:0];
				c = (op[2:0] == REG_M) ? 5'd7 : 5'd4;
			end
			default: begin
				if ((op & 8'h0B) == 8'h01) begin
					e.cls  = op[2] ? CLS_PUSH : CLS_POP;
					c      = op[2] ? 5'd11 : 5'd10;
					e.pair = op[5:4];
				end else if (op[2:0] == 3'd6) begin
					e.cls = CLS_ALU_IMM; c = 5'd7; e.sub = op[5:3];
				end else if (op[5:0] == 6'h03) begin
					e.cls = CLS_JMP; c = 5'd10; e.uncond_taken = 1'b1;
				end else if (op[5:0] == 6'h09) begin
					e.cls = CLS_RET; c = 5'd10; e.uncond_taken = 1'b1;
				end else if (op[5:0] == 6'h0D) begin
					e.cls = CLS_CALL; c = 5'd17; e.uncond_taken = 1'b1;
				end else if (op[5:0] == 6'h13) begin
					e.cls = CLS_OUT; c = 5'd10;
				end else if (op[5:0] == 6'h1B) begin
					e.cls = CLS_IN; c = 5'd10;
				end else if (op[5:0] == 6'h23) begin
					e.cls = CLS_XTHL; c = 5'd18;
				end else if (op[5:0] == 6'h29) begin
					e.cls = CLS_PCHL; c = 5'd5; e.uncond_taken = 1'b1;
				end else if (op[5:0] == 6'h2B) begin
					e.cls = CLS_XCHG; c = 5'd4;
				end else if (op[5:0] == 6'h33) begin
					e.cls = CLS_DI; c = 5'd4;
				end else if (op[5:0] == 6'h3B) begin
					e.cls = CLS_EI; c = 5'd4;
				end else if (!op[0] && op[2:1] != 2'd3) begin
					e.is_cond  = 1'b1;
					e.cond_sel = op[5:4];
					e.cond_val = op[3];
					case (op[2:1])
						KIND_RET: begin
							e.cls = CLS_RET; c = 5'd11; e.cost_untaken = 5'd5;
						end
						KIND_CALL: begin
							e.cls = CLS_CALL; c = 5'd17; e.cost_untaken = 5'd11;
							e.may_skip = 1'b1;
						end
						default: begin
							e.cls = CLS_JMP; c = 5'd10; e.cost_untaken = 5'd10;
							e.may_skip = 1'b1;
						end
					endcase
				end else begin
					e.fault = FAULT_UNIMP;
				end
			end
		endcase
		e.cost_taken = c;
		if (!e.is_cond) e.cost_untaken = c;
		if (e.fault != FAULT_NONE) begin
			e       = '0;
			e.fault = (op == OP_HLT) ? FAULT_HALT : FAULT_UNIMP;
			e.cls   = CLS_NONE;
		end
		return e;
	endfunction

endpackage

/* src/i8080_opcode_decoder.sv */
// ----------------------------------------------------------------------------
// i8080_opcode_decoder
// 8080 opcode decoder: class, operands, cycle cost, branch outcome and faults.
// ----------------------------------------------------------------------------
// Takes one opcode word per clock and returns one result word per opcode: the
// opcode addresses the decode ROM, whose output is registered; then the zero,
// carry, parity and sign flags are applied and the result loads the output
// register. The ROM read port and the output register set the rate of one word
// per cycle; back-pressure on the output stalls both stages.
module i8080_opcode_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] opcode_byte, [8] zero_flag, [9] carry_flag, [10] parity_flag,
	// [11] sign_flag, [15:12] zero
	input  logic [15:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [4:0] op_class, [7:5] sub_op, [10:8] dest_code, [13:11] src_code,
	// [15:14] pair_code, [20:16] cycle_cost, [21] branch_taken,
	// [22] skip_operand, [24:23] fault_code, [31:25] zero
	output logic [31:0] m_axis_tdata
);
	import i8080d_pkg::*;

	logic       valid_s1;
	flags_t     flags_s1;
	rom_entry_t entry_s1;
	result_t    res_comb;
	result_t    res_q;
	logic       out_valid_q;
	logic       s1_adv;
	logic       in_acc;

	assign s1_adv        = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || s1_adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	i8080d_rom u_rom (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (s_axis_tdata[OpcodeW-1:0]),
		.rd_data (entry_s1)
	);

	i8080d_resolve u_resolve (
		.entry  (entry_s1),
		.flags  (flags_s1),
		.result (res_comb)
	);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			flags_s1.zero   <= s_axis_tdata[8];
			flags_s1.carry  <= s_axis_tdata[9];
			flags_s1.parity <= s_axis_tdata[10];
			flags_s1.sign   <= s_axis_tdata[11];
		end
		if (valid_s1 && s1_adv) res_q <= res_comb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready) valid_s1 <= s_axis_tvalid;
			if (s1_adv) out_valid_q <= valid_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, res_q.fault, res_q.skip, res_q.taken, res_q.cost,
		res_q.pair, res_q.src, res_q.dst, res_q.sub, res_q.cls};

endmodule

/* src/i8080d_rom.sv */
// ----------------------------------------------------------------------------
// i8080d_rom
// Synchronous decode ROM indexed by opcode, with registered read data.
// ----------------------------------------------------------------------------
module i8080d_rom (
	input  logic                              clk,
	input  logic                              rd_en,
	input  logic [i8080d_pkg::OpcodeW-1:0]    rd_addr,
	output i8080d_pkg::rom_entry_t            rd_data
);
	import i8080d_pkg::*;

	rom_entry_t data_q;

	always_ff @(posedge clk) begin
		if (rd_en) data_q <= rom_data(rd_addr);
	end

	assign rd_data = data_q;

endmodule

/* src/i8080d_resolve.sv */
// ----------------------------------------------------------------------------
// i8080d_resolve
// Apply the condition flags to a decode entry and form the result word.
// ----------------------------------------------------------------------------
module i8080d_resolve (
	input  i8080d_pkg::rom_entry_t entry,
	input  i8080d_pkg::flags_t     flags,
	output i8080d_pkg::result_t    result
);
	import i8080d_pkg::*;

	logic flag_sel;
	logic ok;

	always_comb begin
		case (entry.cond_sel)
			2'd0:    flag_sel = flags.zero;
			2'd1:    flag_sel = flags.carry;
			2'd2:    flag_sel = flags.parity;
			default: flag_sel = flags.sign;
		endcase
		ok = (flag_sel == entry.cond_val);
		result.cls   = entry.cls;
		result.sub   = entry.sub;
		result.dst   = entry.dst;
		result.src   = entry.src;
		result.pair  = entry.pair;
		result.cost  = (ok || !entry.is_cond) ? entry.cost_taken : entry.cost_untaken;
		result.taken = entry.uncond_taken | (entry.is_cond & ok);
		result.skip  = entry.may_skip & entry.is_cond & ~ok;
		result.fault = entry.fault;
	end

endmodule

/* src/i8080d_checker.sv */
// ----------------------------------------------------------------------------
// i8080d_checker
// Port-level checks of the opcode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module i8080d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);
	import i8080d_pkg::*;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed while stalled");

	a_fault_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24:23] != FAULT_NONE
		|-> m_axis_tdata[22:5] == 18'd0 && m_axis_tdata[4:0] == CLS_NONE)
		else $error("faulted word carries decode fields");

	a_skip_untaken: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[22] && m_axis_tdata[21]))
		else $error("skip and taken both set");

	a_cost_present: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[24:23] == FAULT_NONE |-> m_axis_tdata[20:16] != 5'd0)
		else $error("decoded word with zero cycle cost");

	a_fault_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[24:23] != 2'd3)
		else $error("illegal fault code");

endmodule

bind i8080_opcode_decoder i8080d_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
